@@ sv/pff_pkg.sv @@
package pff_pkg;

   localparam int CHARS_DEF    = 8;
   localparam int CHUNK_SLOTS  = 8;
   localparam int MAX_FIELD    = 64;
   localparam int DIGIT_BUFFER = 64;
   localparam int LEN_W        = 7;
   localparam int DIG_W        = 7;

   localparam logic [7:0] ASC_SPACE = 8'h20;
   localparam logic [7:0] ASC_PLUS  = 8'h2B;
   localparam logic [7:0] ASC_MINUS = 8'h2D;
   localparam logic [7:0] ASC_ZERO  = 8'h30;
   localparam logic [7:0] ASC_UA    = 8'h41;
   localparam logic [7:0] ASC_LA    = 8'h61;
   localparam logic [7:0] ASC_UB    = 8'h42;
   localparam logic [7:0] ASC_LB    = 8'h62;
   localparam logic [7:0] ASC_UX    = 8'h58;
   localparam logic [7:0] ASC_LX    = 8'h78;

   typedef struct packed {
      logic [63:0]      mag;
      logic [4:0]       base;
      logic [7:0]       pre0;
      logic [7:0]       pre1;
      logic [1:0]       plen;
      logic [LEN_W-1:0] width;
      logic [LEN_W-1:0] prec;
      logic             left;
      logic             zmode;
      logic             upper;
   } pff_desc_type;

   typedef struct packed {
      logic [CHUNK_SLOTS-1:0][7:0] chars;
      logic [3:0]                  cnt;
      logic                        last;
   } pff_chunk_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] d8;
      d8 = {4'd0, d};
      if (d < 4'd10) begin
         digit_char = ASC_ZERO + d8;
      end else begin
         digit_char = (upper ? ASC_UA : ASC_LA) + d8 - 8'd10;
      end
   endfunction

endpackage

@@ sv/printf_integer_formatter_top.sv @@
// The digits are divided out first (at least one), then a setup step runs, then the
// characters are emitted. One item is formatted at a time; the 8-bit-per-cycle division
// loop and the character output, held while the output queue is full, set the rate.
// A two-entry queue on each side lets input and output stall independently.
// Reset is synchronous and active high; it empties both queues and idles the engine.
module printf_integer_formatter_top import pff_pkg::*; #(
   parameter int CHARS_PER_RESULT = CHARS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [63:0]       req_value,
   input  logic              req_is_signed,
   input  logic [4:0]        req_radix,
   input  logic              req_flag_upper,
   input  logic              req_flag_hash,
   input  logic              req_flag_zero,
   input  logic              req_flag_left,
   input  logic              req_flag_plus,
   input  logic              req_flag_space,
   input  logic [6:0]        req_field_width,
   input  logic signed [7:0] req_min_digits,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [7:0]        rsp_char_0,
   output logic [7:0]        rsp_char_1,
   output logic [7:0]        rsp_char_2,
   output logic [7:0]        rsp_char_3,
   output logic [7:0]        rsp_char_4,
   output logic [7:0]        rsp_char_5,
   output logic [7:0]        rsp_char_6,
   output logic [7:0]        rsp_char_7,
   output logic [3:0]        rsp_char_count,
   output logic              rsp_last_chunk
);

   pff_desc_type  desc;
   pff_chunk_type chunk;
   logic          desc_valid, desc_pop;

   pff_front u_front (
      .clock(clock), .reset(reset), .push(req_push), .full(req_full),
      .value(req_value), .is_signed(req_is_signed), .radix(req_radix),
      .flag_upper(req_flag_upper), .flag_hash(req_flag_hash),
      .flag_zero(req_flag_zero), .flag_left(req_flag_left),
      .flag_plus(req_flag_plus), .flag_space(req_flag_space),
      .field_width(req_field_width), .min_digits(req_min_digits),
      .desc_valid(desc_valid), .desc_pop(desc_pop), .desc(desc)
   );

   pff_back #(.CHARS_PER_RESULT(CHARS_PER_RESULT)) u_back (
      .clock(clock), .reset(reset), .desc_valid(desc_valid), .desc_pop(desc_pop),
      .desc(desc), .out_empty(rsp_empty), .out_pop(rsp_pop), .out_chunk(chunk)
   );

   assign rsp_char_0 = chunk.chars[0];
   assign rsp_char_1 = chunk.chars[1];
   assign rsp_char_2 = chunk.chars[2];
   assign rsp_char_3 = chunk.chars[3];
   assign rsp_char_4 = chunk.chars[4];
   assign rsp_char_5 = chunk.chars[5];
   assign rsp_char_6 = chunk.chars[6];
   assign rsp_char_7 = chunk.chars[7];
   assign rsp_char_count = chunk.cnt;
   assign rsp_last_chunk = chunk.last;

endmodule

@@ sv/pff_front.sv @@
module pff_front import pff_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [63:0]        value,
   input  logic               is_signed,
   input  logic [4:0]         radix,
   input  logic               flag_upper,
   input  logic               flag_hash,
   input  logic               flag_zero,
   input  logic               flag_left,
   input  logic               flag_plus,
   input  logic               flag_space,
   input  logic [6:0]         field_width,
   input  logic signed [7:0]  min_digits,
   output logic               desc_valid,
   input  logic               desc_pop,
   output pff_desc_type       desc
);

   pff_desc_type q_ff [2];
   logic         wp_ff, rp_ff;
   logic [1:0]   cnt_ff;
   pff_desc_type d_in;
   logic         neg, given, do_push, do_pop;

   always_comb begin
      d_in = '0;
      neg = is_signed & value[63];
      d_in.mag = neg ? (~value + 64'd1) : value;
      d_in.base = (radix inside {[5'd2:5'd16]}) ? radix : 5'd10;
      d_in.pre0 = ASC_ZERO;
      d_in.pre1 = ASC_ZERO;
      d_in.plen = 2'd0;
      if (is_signed) begin
         d_in.plen = 2'd1;
         if (neg) d_in.pre0 = ASC_MINUS;
         else if (flag_plus) d_in.pre0 = ASC_PLUS;
         else if (flag_space) d_in.pre0 = ASC_SPACE;
         else d_in.plen = 2'd0;
      end else if (flag_hash && value != 64'd0) begin
         if (radix == 5'd16) begin
            d_in.pre1 = flag_upper ? ASC_UX : ASC_LX;
            d_in.plen = 2'd2;
         end else if (radix == 5'd8) begin
            d_in.plen = 2'd1;
         end else if (radix == 5'd2) begin
            d_in.pre1 = flag_upper ? ASC_UB : ASC_LB;
            d_in.plen = 2'd2;
         end
      end
      given = ~min_digits[7];
      d_in.width = (field_width > LEN_W'(MAX_FIELD)) ? LEN_W'(MAX_FIELD) : field_width;
      if (!given) d_in.prec = LEN_W'(1);
      else if (min_digits[6:0] > LEN_W'(MAX_FIELD)) d_in.prec = LEN_W'(MAX_FIELD);
      else d_in.prec = min_digits[6:0];
      d_in.left = flag_left;
      d_in.zmode = flag_zero & ~flag_left & ~given;
      d_in.upper = ~is_signed & flag_upper;
   end

   assign full = (cnt_ff == 2'd2);
   assign do_push = push & ~full;
   assign do_pop = desc_pop & (cnt_ff != 2'd0);
   assign desc_valid = (cnt_ff != 2'd0);
   assign desc = q_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (do_push) q_ff[wp_ff] <= d_in;
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (do_push) wp_ff <= ~wp_ff;
         if (do_pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

endmodule

@@ sv/pff_back.sv @@
module pff_back import pff_pkg::*; #(
   parameter int CHARS_PER_RESULT = CHARS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          desc_valid,
   output logic          desc_pop,
   input  pff_desc_type  desc,
   output logic          out_empty,
   input  logic          out_pop,
   output pff_chunk_type out_chunk
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_DIV   = 2'd1;
   localparam logic [1:0] ST_SETUP = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;
   localparam int DBW = 4 * DIGIT_BUFFER;

   logic [1:0]         state_ff, state_in;
   pff_desc_type       desc_ff;
   logic [63:0]        quot_ff, quot_in;
   logic [3:0]         rem_ff, rem_in;
   logic [2:0]         bit_ff;
   logic [DIG_W-1:0]   nlen_ff, nlen_in;
   logic [DBW-1:0]     dig_ff, dig_in;
   logic [LEN_W-1:0]   pos_ff, pos_in;
   logic [LEN_W-1:0]   bsp_ff, bpre_ff, bzero_ff, bdig_ff, len_ff;
   logic [LEN_W-1:0]   bsp_in, bpre_in, bzero_in, bdig_in, len_in;
   pff_chunk_type      chunk_ff, chunk_in;
   pff_chunk_type      push_chunk;
   pff_chunk_type      ob_ff [2];
   logic               owp_ff, orp_ff;
   logic [1:0]         ocnt_ff;
   logic               opush, opop;
   logic [63:0]        w;
   logic [4:0]         r;
   logic [LEN_W-1:0]   zeros, total, pad, zc, sp;
   logic [7:0]         ch;
   logic               step;

   // long division of the magnitude by the base, eight quotient bits per cycle
   always_comb begin
      w = quot_ff;
      r = {1'b0, rem_ff};
      for (int i = 0; i < 8; i++) begin
         r = {r[3:0], w[63]};
         w = {w[62:0], r >= desc_ff.base};
         if (r >= desc_ff.base) r = r - desc_ff.base;
      end
   end

   always_comb begin
      zeros = (desc_ff.prec > nlen_ff) ? desc_ff.prec - nlen_ff : '0;
      total = LEN_W'(desc_ff.plen) + nlen_ff + zeros;
      pad = (desc_ff.width > total) ? desc_ff.width - total : '0;
      zc = desc_ff.zmode ? zeros + pad : zeros;
      sp = desc_ff.zmode ? '0 : pad;
      bsp_in = desc_ff.left ? '0 : sp;
      bpre_in = bsp_in + LEN_W'(desc_ff.plen);
      bzero_in = bpre_in + zc;
      bdig_in = bzero_in + nlen_ff;
      len_in = bdig_in + (desc_ff.left ? sp : '0);
   end

   always_comb begin
      if (pos_ff < bsp_ff) ch = ASC_SPACE;
      else if (pos_ff < bpre_ff) ch = (pos_ff == bsp_ff) ? desc_ff.pre0 : desc_ff.pre1;
      else if (pos_ff < bzero_ff) ch = ASC_ZERO;
      else if (pos_ff < bdig_ff) ch = digit_char(dig_ff[3:0], desc_ff.upper);
      else ch = ASC_SPACE;
   end

   assign step = (state_ff == ST_EMIT) && (ocnt_ff != 2'd2);

   always_comb begin
      state_in = state_ff;
      quot_in = quot_ff;
      rem_in = rem_ff;
      nlen_in = nlen_ff;
      dig_in = dig_ff;
      pos_in = pos_ff;
      chunk_in = chunk_ff;
      opush = 1'b0;
      desc_pop = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (desc_valid) begin
               desc_pop = 1'b1;
               quot_in = desc.mag;
               rem_in = 4'd0;
               nlen_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            quot_in = w;
            rem_in = r[3:0];
            if (bit_ff == 3'd7) begin
               dig_in = {dig_ff[DBW-5:0], r[3:0]};
               nlen_in = nlen_ff + DIG_W'(1);
               rem_in = 4'd0;
               if (w == 64'd0) state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            pos_in = '0;
            chunk_in = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (step) begin
               chunk_in.chars[chunk_ff.cnt[2:0]] = ch;
               chunk_in.cnt = chunk_ff.cnt + 4'd1;
               chunk_in.last = (pos_ff + LEN_W'(1) == len_ff);
               pos_in = pos_ff + LEN_W'(1);
               if (pos_ff >= bzero_ff && pos_ff < bdig_ff) dig_in = dig_ff >> 4;
               if (chunk_in.last || chunk_in.cnt == 4'(CHARS_PER_RESULT)) begin
                  opush = 1'b1;
                  chunk_in = '0;
               end
               if (pos_ff + LEN_W'(1) == len_ff) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      push_chunk = chunk_ff;
      push_chunk.chars[chunk_ff.cnt[2:0]] = ch;
      push_chunk.cnt = chunk_ff.cnt + 4'd1;
      push_chunk.last = (pos_ff + LEN_W'(1) == len_ff);
   end

   assign opop = out_pop & (ocnt_ff != 2'd0);
   assign out_empty = (ocnt_ff == 2'd0);
   assign out_chunk = ob_ff[orp_ff];

   always_ff @(posedge clock) begin
      if (desc_pop) desc_ff <= desc;
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      nlen_ff <= nlen_in;
      dig_ff <= dig_in;
      pos_ff <= pos_in;
      chunk_ff <= chunk_in;
      if (state_ff == ST_SETUP) begin
         bsp_ff <= bsp_in;
         bpre_ff <= bpre_in;
         bzero_ff <= bzero_in;
         bdig_ff <= bdig_in;
         len_ff <= len_in;
      end
      if (opush) ob_ff[owp_ff] <= push_chunk;
      if (reset) begin
         state_ff <= ST_IDLE;
         bit_ff <= 3'd0;
         owp_ff <= 1'b0;
         orp_ff <= 1'b0;
         ocnt_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         bit_ff <= (state_ff == ST_DIV) ? bit_ff + 3'd1 : 3'd0;
         if (opush) owp_ff <= ~owp_ff;
         if (opop) orp_ff <= ~orp_ff;
         ocnt_ff <= ocnt_ff + {1'b0, opush} - {1'b0, opop};
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      opush |-> ocnt_ff != 2'd2)
      else $error("result buffer overflow");
   a_chunk_cnt: assert property (@(posedge clock) disable iff (reset)
      opush |-> (push_chunk.cnt != 4'd0 && push_chunk.cnt <= 4'(CHARS_PER_RESULT)))
      else $error("chunk count out of range");
   a_digits: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> (nlen_ff != '0 && nlen_ff <= DIG_W'(DIGIT_BUFFER)))
      else $error("digit count out of range");
   a_pos: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> pos_ff < len_ff)
      else $error("emit position past end of text");
`endif

endmodule
